[hdl/max_pool_2d_stream_defines.svh]
// Assertion macros shared by the max pooling RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MP2D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MP2D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mp2d_pkg.sv]
// Package for the 2-D max pooling stream: widths, register indexes, reset values.
// No dependencies.
`default_nettype none
package mp2d_pkg;

  localparam int DEF_MAX_LINE_WIDTH = 256;

  localparam int SAMPLE_W = 16;
  localparam int POOL_W   = 4;
  localparam int DIM_W    = 9;
  localparam int CHAN_W   = 10;
  localparam int PHASE_W  = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 10;
  // rows of the pooled area: out_height times pool_size
  localparam int ROWS_W   = DIM_W + POOL_W;

  typedef enum logic [CFG_AW-1:0] {
    REG_POOL_SIZE  = 3'd0,
    REG_IN_WIDTH   = 3'd1,
    REG_IN_HEIGHT  = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4,
    REG_CHANNELS   = 3'd5
  } cfg_reg_t;

  localparam logic [POOL_W-1:0] RST_POOL_SIZE  = 4'd2;
  localparam logic [DIM_W-1:0]  RST_IN_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]  RST_IN_HEIGHT  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_OUT_WIDTH  = 9'd128;
  localparam logic [DIM_W-1:0]  RST_OUT_HEIGHT = 9'd128;
  localparam logic [CHAN_W-1:0] RST_CHANNELS   = 10'd1;

  localparam logic [POOL_W-1:0] POOL_MAX = 4'd8;

  // per-beat decisions taken at acceptance, carried to the merge stage
  typedef struct packed {
    logic in_area;    // inside the pooled area
    logic seg_end;    // last column of a window segment
    logic col_first;  // first column of a window segment
    logic row_first;  // first row of a window
    logic emit;       // last row of a window
    logic last;       // final window of the volume
  } beat_ctrl_t;

endpackage
`default_nettype wire

[hdl/mp2d_line_store.sv]
// Line store of partial window maxima, one entry per pooled column.
// Single write port, one registered read port. Uses mp2d_pkg.
`default_nettype none
module mp2d_line_store #(
  parameter int DEPTH = mp2d_pkg::DEF_MAX_LINE_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [AW-1:0]                       wr_addr,
  input  wire logic signed [mp2d_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                                rd_en,
  input  wire logic [AW-1:0]                       rd_addr,
  output logic signed [mp2d_pkg::SAMPLE_W-1:0]     rd_data
);

  logic signed [mp2d_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on a clash; the caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/max_pool_2d_stream.sv]
// Top level of the streaming 2-D max pooling block (non-overlapping windows).
// Depends on mp2d_pkg, mp2d_line_store and max_pool_2d_stream_defines.svh.
//
//   port group   dir   payload
//   s_*          in    s_tdata[15:0] = sample (signed)
//   m_*          out   m_tdata[15:0] = max_value (signed), m_tlast = last
//   cfg_*        in    cfg_addr = register index, cfg_wdata = value
//
// One beat per cycle while m_tready holds high; the result is registered after stage two.
// Stage one is the position counters and the line store read; stage two does
// the running max, the merge with the line store entry and the write back.
// A write back to the entry read in the same cycle is forwarded.
// Stalls on m_tready ripple back: s_tready drops only while both stages hold.
// rst is synchronous: counters, running max and config go to reset values;
// the line store is not cleared (each entry is written before it is used).
`default_nettype none
`include "max_pool_2d_stream_defines.svh"
module max_pool_2d_stream #(
  parameter int MAX_LINE_WIDTH = mp2d_pkg::DEF_MAX_LINE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample[15:0]
  input  wire logic [mp2d_pkg::SAMPLE_W-1:0] s_tdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // max_value[15:0]
  output logic [mp2d_pkg::SAMPLE_W-1:0]      m_tdata,
  output logic                               m_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          cfg_we,
  input  wire logic [mp2d_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [mp2d_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int AW   = $clog2(MAX_LINE_WIDTH);
  localparam int OCW  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMPW = (OCW > mp2d_pkg::DIM_W) ? OCW : mp2d_pkg::DIM_W;

  // ---------------------------------------------------------------- config
  logic [mp2d_pkg::POOL_W-1:0] pool_size;
  logic [mp2d_pkg::DIM_W-1:0]  in_width, in_height, out_width, out_height;
  logic [mp2d_pkg::CHAN_W-1:0] channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= mp2d_pkg::RST_POOL_SIZE;
      in_width   <= mp2d_pkg::RST_IN_WIDTH;
      in_height  <= mp2d_pkg::RST_IN_HEIGHT;
      out_width  <= mp2d_pkg::RST_OUT_WIDTH;
      out_height <= mp2d_pkg::RST_OUT_HEIGHT;
      channels   <= mp2d_pkg::RST_CHANNELS;
    end else if (cfg_we) begin
      unique case (mp2d_pkg::cfg_reg_t'(cfg_addr))
        mp2d_pkg::REG_POOL_SIZE:  pool_size  <= cfg_wdata[mp2d_pkg::POOL_W-1:0];
        mp2d_pkg::REG_IN_WIDTH:   in_width   <= cfg_wdata[mp2d_pkg::DIM_W-1:0];
        mp2d_pkg::REG_IN_HEIGHT:  in_height  <= cfg_wdata[mp2d_pkg::DIM_W-1:0];
        mp2d_pkg::REG_OUT_WIDTH:  out_width  <= cfg_wdata[mp2d_pkg::DIM_W-1:0];
        mp2d_pkg::REG_OUT_HEIGHT: out_height <= cfg_wdata[mp2d_pkg::DIM_W-1:0];
        mp2d_pkg::REG_CHANNELS:   channels   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective limits: zero reads as one, pool clamped to 8, width to the store
  logic [mp2d_pkg::PHASE_W-1:0] pk_m1;
  logic [mp2d_pkg::POOL_W-1:0]  pk_eff;
  logic [mp2d_pkg::DIM_W-1:0]   iw_m1, ih_m1, oh_eff;
  logic [mp2d_pkg::CHAN_W-1:0]  ch_m1;
  logic [CMPW-1:0]              ow_wide;
  logic [OCW-1:0]               ow_eff;
  logic [mp2d_pkg::ROWS_W-1:0]  rows_lim;

  always_comb begin
    if (pool_size == '0) begin
      pk_eff = mp2d_pkg::POOL_W'(1);
    end else if (pool_size > mp2d_pkg::POOL_MAX) begin
      pk_eff = mp2d_pkg::POOL_MAX;
    end else begin
      pk_eff = pool_size;
    end
    pk_m1  = mp2d_pkg::PHASE_W'(pk_eff - mp2d_pkg::POOL_W'(1));
    iw_m1  = (in_width  == '0) ? '0 : in_width  - mp2d_pkg::DIM_W'(1);
    ih_m1  = (in_height == '0) ? '0 : in_height - mp2d_pkg::DIM_W'(1);
    ch_m1  = (channels  == '0) ? '0 : channels  - mp2d_pkg::CHAN_W'(1);
    oh_eff = (out_height == '0) ? mp2d_pkg::DIM_W'(1) : out_height;
    ow_wide = (out_width == '0) ? CMPW'(1) : CMPW'(out_width);
    if (ow_wide > CMPW'(MAX_LINE_WIDTH)) begin
      ow_wide = CMPW'(MAX_LINE_WIDTH);
    end
    ow_eff   = OCW'(ow_wide);
    rows_lim = mp2d_pkg::ROWS_W'(oh_eff) * mp2d_pkg::ROWS_W'(pk_eff);
  end

  // ------------------------------------------------- stage one: positions
  logic [mp2d_pkg::DIM_W-1:0]   col_pos, row_pos;
  logic [mp2d_pkg::DIM_W-1:0]   col_pos_next, row_pos_next;
  logic [mp2d_pkg::PHASE_W-1:0] wcol_ph, wrow_ph, wcol_ph_next, wrow_ph_next;
  logic [OCW-1:0]               out_col, out_col_next;
  logic [mp2d_pkg::CHAN_W-1:0]  chan_pos, chan_pos_next;
  mp2d_pkg::beat_ctrl_t         ctrl_next;

  logic s_valid;   // stage two occupied
  logic s2_go;     // stage two commits this edge
  logic o_valid;
  logic in_beat;

  assign s2_go    = s_valid && (!o_valid || m_tready);
  assign s_tready = !s_valid || s2_go;
  assign in_beat  = s_tvalid && s_tready;

  always_comb begin
    ctrl_next.in_area   = (CMPW'(out_col) < CMPW'(ow_eff))
                       && (mp2d_pkg::ROWS_W'(row_pos) < rows_lim);
    ctrl_next.seg_end   = wcol_ph >= pk_m1;
    ctrl_next.col_first = wcol_ph == '0;
    ctrl_next.row_first = wrow_ph == '0;
    ctrl_next.emit      = wrow_ph >= pk_m1;
    ctrl_next.last      = (chan_pos == ch_m1)
                       && (mp2d_pkg::ROWS_W'(row_pos) == rows_lim - mp2d_pkg::ROWS_W'(1))
                       && (out_col == ow_eff - OCW'(1));

    // window column phase and pooled column
    col_pos_next  = col_pos;
    row_pos_next  = row_pos;
    wcol_ph_next  = wcol_ph;
    wrow_ph_next  = wrow_ph;
    out_col_next  = out_col;
    chan_pos_next = chan_pos;
    if (wcol_ph >= pk_m1) begin
      wcol_ph_next = '0;
      if (out_col < ow_eff) begin
        out_col_next = out_col + OCW'(1);
      end
    end else begin
      wcol_ph_next = wcol_ph + mp2d_pkg::PHASE_W'(1);
    end
    // end of input row, end of channel
    if (col_pos >= iw_m1) begin
      col_pos_next = '0;
      wcol_ph_next = '0;
      out_col_next = '0;
      wrow_ph_next = (wrow_ph >= pk_m1) ? '0 : wrow_ph + mp2d_pkg::PHASE_W'(1);
      if (row_pos >= ih_m1) begin
        row_pos_next  = '0;
        wrow_ph_next  = '0;
        chan_pos_next = (chan_pos >= ch_m1) ? '0 : chan_pos + mp2d_pkg::CHAN_W'(1);
      end else begin
        row_pos_next = row_pos + mp2d_pkg::DIM_W'(1);
      end
    end else begin
      col_pos_next = col_pos + mp2d_pkg::DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      wcol_ph  <= '0;
      wrow_ph  <= '0;
      out_col  <= '0;
      chan_pos <= '0;
    end else if (in_beat) begin
      col_pos  <= col_pos_next;
      row_pos  <= row_pos_next;
      wcol_ph  <= wcol_ph_next;
      wrow_ph  <= wrow_ph_next;
      out_col  <= out_col_next;
      chan_pos <= chan_pos_next;
    end
  end

  // stage register
  mp2d_pkg::beat_ctrl_t                 s_ctrl;
  logic signed [mp2d_pkg::SAMPLE_W-1:0] s_sample;
  logic [OCW-1:0]                       s_oc;
  logic                                 s_fwd;
  logic signed [mp2d_pkg::SAMPLE_W-1:0] s_fwd_data;

  // ------------------------------------------------- stage two: merge
  logic signed [mp2d_pkg::SAMPLE_W-1:0] running_max, rm_next, line_val, merged;
  logic signed [mp2d_pkg::SAMPLE_W-1:0] line_rd;
  logic                                 wr_en;
  logic [AW-1:0]                        rd_addr;

  assign rd_addr = out_col[AW-1:0];

  always_comb begin
    if (s_ctrl.col_first || s_sample > running_max) begin
      rm_next = s_sample;
    end else begin
      rm_next = running_max;
    end
    line_val = s_fwd ? s_fwd_data : line_rd;
    if (s_ctrl.row_first || rm_next > line_val) begin
      merged = rm_next;
    end else begin
      merged = line_val;
    end
    wr_en = s2_go && s_ctrl.in_area && s_ctrl.seg_end;
  end

  mp2d_line_store #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_oc[AW-1:0]),
    .wr_data (merged),
    .rd_en   (in_beat),
    .rd_addr (rd_addr),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_beat) begin
      s_valid <= 1'b1;
    end else if (s2_go) begin
      s_valid <= 1'b0;
    end
  end

  // payload of stage two; forward flag catches a write back to the entry read now
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s_ctrl     <= ctrl_next;
      s_sample   <= s_tdata;
      s_oc       <= out_col;
      s_fwd      <= wr_en && (s_oc[AW-1:0] == rd_addr);
      s_fwd_data <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (s2_go && s_ctrl.in_area) begin
      running_max <= rm_next;
    end
  end

  // ------------------------------------------------- result register
  logic signed [mp2d_pkg::SAMPLE_W-1:0] max_value_q;
  logic                                 last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (wr_en && s_ctrl.emit) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s_ctrl.emit) begin
      max_value_q <= merged;
      last_q      <= s_ctrl.last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = max_value_q;
  assign m_tlast  = last_q;

  // ------------------------------------------------- checks
  `MP2D_ASSERT_NXT(a_stage_hold, s_valid && !s2_go, s_valid, "stage two beat dropped")
  `MP2D_ASSERT_IMP(a_addr_range, s_valid && s_ctrl.in_area, CMPW'(s_oc) < CMPW'(ow_eff), "line store address out of range")
  `MP2D_ASSERT_NXT(a_result_kept, o_valid && !m_tready, o_valid && $stable(max_value_q), "pending result lost")
  `MP2D_ASSERT_IMP(a_no_overrun, s_valid && !s2_go, !s_tready, "beat accepted into a full stage")

endmodule
`default_nettype wire
